@@ design/thsa_pkg.sv @@
// ============================================================================
// thsa_pkg: shared types and constants for the tagged handle slot allocator
// Command codes, payload structs, sequencer states and table geometry.
// ============================================================================
`default_nettype none

package thsa_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 512;
    localparam int MAP_W      = 32;                              // slots per bitmap word
    localparam int MAP_BW     = $clog2(MAP_W);
    localparam int WORD_COUNT = (SLOT_COUNT + MAP_W - 1) / MAP_W;
    localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);
    localparam int SLOT_W     = WORD_AW + MAP_BW;                // scan position width

    // Field widths
    localparam int HANDLE_W = 32;
    localparam int SERIAL_W = 32;
    localparam int LIVE_W   = 10;
    localparam int DAMAGE_W = 32;
    localparam int INDEX_W  = 24;
    localparam int ENTRY_W  = SERIAL_W + 1;                      // {visible, serial}

    localparam logic [7:0]          TAG_BYTE  = 8'h80;
    localparam logic [HANDLE_W-1:0] TAG_VALUE = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_CREATE      = 2'd0,
        CMD_SET_VISIBLE = 2'd1,
        CMD_QUERY       = 2'd2,
        CMD_FREE_ALL    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_LOOKUP,
        ST_FREE,
        ST_RESP
    } state_t;

    typedef struct packed {
        cmd_t                command;
        logic [HANDLE_W-1:0] handle;
        logic                visible_flag;
    } in_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] new_handle;
        logic                found;
        logic                drawable;
        logic [SERIAL_W-1:0] object_serial;
        logic [LIVE_W-1:0]   live_objects;
        logic [DAMAGE_W-1:0] damage_total;
    } out_t;

    // Answer of the first-free finder
    typedef struct packed {
        logic             hit;
        logic [MAP_BW-1:0] idx;
    } pick_t;

    // Bits of the last bitmap word that lie beyond the table read as taken
    function automatic logic [MAP_W-1:0] last_pad();
        logic [MAP_W-1:0] pad;
        pad = '0;
        for (int b = 0; b < MAP_W; b++) begin
            if ((WORD_COUNT - 1) * MAP_W + b >= SLOT_COUNT) begin
                pad[b] = 1'b1;
            end
        end
        return pad;
    endfunction

    localparam logic [MAP_W-1:0] LAST_PAD = last_pad();

endpackage

`default_nettype wire

@@ design/thsa_ram.sv @@
// ============================================================================
// thsa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module thsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ design/thsa_ffz.sv @@
// ============================================================================
// thsa_ffz: first free slot finder
// Report the lowest clear bit of one occupancy bitmap word.
// ============================================================================
`default_nettype none

module thsa_ffz (
    input  wire logic [thsa_pkg::MAP_W-1:0] word,
    output thsa_pkg::pick_t                 pick
);

    import thsa_pkg::*;

    always_comb begin
        pick = '0;
        // Walk down so the lowest clear bit wins
        for (int b = MAP_W - 1; b >= 0; b--) begin
            if (!word[b]) begin
                pick.hit = 1'b1;
                pick.idx = MAP_BW'(b);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/tagged_handle_slot_allocator.sv @@
// ============================================================================
// tagged_handle_slot_allocator: object slot table with tagged handles
// Create, set-visible, query and free-all commands over a slot table.
// ============================================================================
// Flow from accept to m_valid: set visible / query pass through ST_LOOKUP when the handle passes the tag
// and range checks (one read of the bitmap and entry RAMs), else go straight to ST_RESP; create scans
// bitmap words up to the first one with a free bit (one word per cycle through the shared finder),
// or goes straight to ST_RESP when the table is full; free all sweeps every bitmap word in ST_FREE.
// A new transaction is taken only in ST_IDLE, after the last result is loaded. Reset: aresetn low clears the
// counters, then a sweep over all WORD_COUNT (16) words zeroes the bitmap while s_ready stays low.
`default_nettype none

module tagged_handle_slot_allocator (
    input  wire logic           aclk,
    input  wire logic           aresetn,

    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire thsa_pkg::in_t  s_payload,

    output logic                m_valid,
    input  wire logic           m_ready,
    output thsa_pkg::out_t      m_payload
);

    import thsa_pkg::*;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t              state_reg,       state_next;
    logic [WORD_AW-1:0]  word_reg,        word_next;      // scan / clear pointer
    cmd_t                cmd_reg,         cmd_next;
    logic [MAP_BW-1:0]   bit_reg,         bit_next;       // bit of the looked-up slot
    logic [SLOT_AW-1:0]  slot_reg,        slot_next;      // looked-up slot
    logic                flag_reg,        flag_next;

    logic [LIVE_W-1:0]   live_count_reg,  live_count_next;
    logic [SERIAL_W-1:0] serial_reg,      serial_next;
    logic [DAMAGE_W-1:0] damage_reg,      damage_next;

    // Result waiting for the output register
    logic [HANDLE_W-1:0] res_handle_reg,  res_handle_next;
    logic                res_found_reg,   res_found_next;
    logic                res_draw_reg,    res_draw_next;
    logic [SERIAL_W-1:0] res_serial_reg,  res_serial_next;

    logic                m_valid_reg,     m_valid_next;
    out_t                m_payload_reg,   m_payload_next;

    // ------------------------------------------------------------------
    // Memories: occupancy bitmap (cleared by sweep) and {visible, serial}
    // per slot (always rewritten by create before it can be read)
    // ------------------------------------------------------------------
    logic                map_we;
    logic [WORD_AW-1:0]  map_waddr;
    logic [MAP_W-1:0]    map_wdata;
    logic [MAP_W-1:0]    map_rdata;

    logic                ent_we;
    logic [SLOT_AW-1:0]  ent_waddr;
    logic [ENTRY_W-1:0]  ent_wdata;
    logic [SLOT_AW-1:0]  ent_raddr;
    logic [ENTRY_W-1:0]  ent_rdata;

    thsa_ram #(
        .WIDTH (MAP_W),
        .DEPTH (WORD_COUNT)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_addr (word_next),
        .rd_data (map_rdata)
    );

    thsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_addr (ent_raddr),
        .rd_data (ent_rdata)
    );

    // ------------------------------------------------------------------
    // Shared first-free finder over the word under scan
    // ------------------------------------------------------------------
    logic [MAP_W-1:0] scan_word;
    pick_t            pick;

    assign scan_word = (word_reg == WORD_AW'(WORD_COUNT - 1)) ? (map_rdata | LAST_PAD)
                                                               : map_rdata;

    thsa_ffz u_ffz (
        .word (scan_word),
        .pick (pick)
    );

    // ------------------------------------------------------------------
    // Handle decode on the incoming transaction
    // ------------------------------------------------------------------
    logic                in_tag_ok;
    logic                in_range_ok;
    logic [INDEX_W-1:0]  in_index;
    logic [SLOT_W-1:0]   scan_slot;
    logic                ent_visible;
    logic [SERIAL_W-1:0] ent_serial;
    logic                occupied;

    assign in_index    = s_payload.handle[INDEX_W-1:0];
    assign in_tag_ok   = (s_payload.handle[HANDLE_W-1:INDEX_W] == TAG_BYTE);
    assign in_range_ok = ({1'b0, in_index} < (INDEX_W + 1)'(SLOT_COUNT));
    assign ent_raddr   = in_index[SLOT_AW-1:0];
    assign scan_slot   = {word_reg, pick.idx};
    assign ent_visible = ent_rdata[ENTRY_W-1];
    assign ent_serial  = ent_rdata[SERIAL_W-1:0];
    assign occupied    = map_rdata[bit_reg];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            word_reg       <= '0;
            live_count_reg <= '0;
            serial_reg     <= '0;
            damage_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            live_count_reg <= live_count_next;
            serial_reg     <= serial_next;
            damage_reg     <= damage_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        bit_reg        <= bit_next;
        slot_reg       <= slot_next;
        flag_reg       <= flag_next;
        res_handle_reg <= res_handle_next;
        res_found_reg  <= res_found_next;
        res_draw_reg   <= res_draw_next;
        res_serial_reg <= res_serial_next;
        m_payload_reg  <= m_payload_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        word_next       = word_reg;
        cmd_next        = cmd_reg;
        bit_next        = bit_reg;
        slot_next       = slot_reg;
        flag_next       = flag_reg;
        live_count_next = live_count_reg;
        serial_next     = serial_reg;
        damage_next     = damage_reg;
        res_handle_next = res_handle_reg;
        res_found_next  = res_found_reg;
        res_draw_next   = res_draw_reg;
        res_serial_next = res_serial_reg;
        m_payload_next  = m_payload_reg;
        // Drop the output once the downstream side takes it
        m_valid_next    = m_valid_reg && !m_ready;

        s_ready   = 1'b0;
        map_we    = 1'b0;
        map_waddr = word_reg;
        map_wdata = '0;
        ent_we    = 1'b0;
        ent_waddr = slot_reg;
        ent_wdata = '0;

        case (state_reg)
            // Zero one bitmap word per cycle, after reset or for free all
            ST_INIT, ST_FREE: begin
                map_we    = 1'b1;
                map_waddr = word_reg;
                map_wdata = '0;
                if (word_reg == WORD_AW'(WORD_COUNT - 1)) begin
                    word_next  = '0;
                    state_next = (state_reg == ST_FREE) ? ST_RESP : ST_IDLE;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next        = s_payload.command;
                    flag_next       = s_payload.visible_flag;
                    bit_next        = in_index[MAP_BW-1:0];
                    slot_next       = in_index[SLOT_AW-1:0];
                    res_handle_next = '0;
                    res_found_next  = 1'b0;
                    res_draw_next   = 1'b0;
                    res_serial_next = '0;
                    case (s_payload.command)
                        CMD_CREATE: begin
                            if (live_count_reg == LIVE_W'(SLOT_COUNT)) begin
                                state_next = ST_RESP;       // table full
                            end else begin
                                word_next  = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_SET_VISIBLE, CMD_QUERY: begin
                            if (in_tag_ok && in_range_ok) begin
                                word_next  = in_index[MAP_BW +: WORD_AW];
                                state_next = ST_LOOKUP;
                            end else begin
                                state_next = ST_RESP;       // handle cannot resolve
                            end
                        end
                        CMD_FREE_ALL: begin
                            live_count_next = '0;
                            word_next       = '0;
                            state_next      = ST_FREE;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            // Scan bitmap words until one has a free bit; claim the lowest
            ST_SCAN: begin
                if (pick.hit) begin
                    map_we          = 1'b1;
                    map_waddr       = word_reg;
                    map_wdata       = map_rdata | (MAP_W'(1) << pick.idx);
                    ent_we          = 1'b1;
                    ent_waddr       = scan_slot[SLOT_AW-1:0];
                    ent_wdata       = {1'b0, serial_reg};
                    res_handle_next = TAG_VALUE | HANDLE_W'(scan_slot);
                    res_serial_next = serial_reg;
                    serial_next     = serial_reg + 1'b1;
                    live_count_next = live_count_reg + 1'b1;
                    state_next      = ST_RESP;
                end else begin
                    word_next = word_reg + 1'b1;
                end
            end

            // Bitmap word and slot entry are back from the RAMs
            ST_LOOKUP: begin
                if (occupied) begin
                    res_found_next  = 1'b1;
                    res_serial_next = ent_serial;
                    if (cmd_reg == CMD_SET_VISIBLE) begin
                        res_draw_next = flag_reg;
                        ent_we        = 1'b1;
                        ent_waddr     = slot_reg;
                        ent_wdata     = {flag_reg, ent_serial};
                        if (ent_visible != flag_reg) begin
                            damage_next = damage_reg + 1'b1;
                        end
                    end else begin
                        res_draw_next = ent_visible;
                    end
                end
                state_next = ST_RESP;
            end

            // Hold until the output register is free, then load it
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                 = 1'b1;
                    m_payload_next.new_handle    = res_handle_reg;
                    m_payload_next.found         = res_found_reg;
                    m_payload_next.drawable      = res_draw_reg;
                    m_payload_next.object_serial = res_serial_reg;
                    m_payload_next.live_objects  = live_count_reg;
                    m_payload_next.damage_total  = damage_reg;
                    state_next                   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_count_reg <= LIVE_W'(SLOT_COUNT))
        else $error("live count beyond table size");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("transaction accepted while sequencer busy");

    a_create_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pick.hit) |=>
            (live_count_reg == LIVE_W'($past(live_count_reg) + 1'b1)) &&
            (serial_reg == SERIAL_W'($past(serial_reg) + 1'b1)))
        else $error("create did not advance live and serial counters");

    a_handle_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.new_handle != '0) |->
            (m_payload.new_handle[HANDLE_W-1:INDEX_W] == TAG_BYTE) && !m_payload.found)
        else $error("created handle lacks tag or reports found");

endmodule

`default_nettype wire

@@ verif/tagged_handle_slot_allocator_tb.sv @@
// ============================================================================
// tagged_handle_slot_allocator_tb: self-checking bench for the slot allocator
// Drives create, set-visible, query and free-all transactions with random
// idling on both channels, predicts every result from a shadow slot table and
// compares each field of each result against the oldest prediction.
// ============================================================================

module tagged_handle_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import thsa_pkg::*;

    // Cycles with no transaction on either channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Cycles to keep watching the result channel after the last prediction drained
    localparam int TAIL_CYCLES = 64;
    // Random transactions to generate after the directed part
    localparam int RANDOM_ITEMS = 1730;
    // Pending count below which both sides stop idling
    localparam int CALM_LEVEL = 120;

    logic   aclk      = 1'b0;
    logic   aresetn   = 1'b0;
    logic   s_valid   = 1'b0;
    logic   s_ready;
    in_t    s_payload = '0;
    logic   m_valid;
    logic   m_ready   = 1'b0;
    out_t   m_payload;

    tagged_handle_slot_allocator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow slot table: what the block should hold after every command
    // ------------------------------------------------------------------------
    logic                tbl_occ [SLOT_COUNT];
    logic                tbl_vis [SLOT_COUNT];
    logic [SERIAL_W-1:0] tbl_serial [SLOT_COUNT];
    logic [LIVE_W-1:0]   tbl_live;
    logic [SERIAL_W-1:0] next_serial;
    logic [DAMAGE_W-1:0] damage_seen;

    // Commands waiting for the driver, with a flag asking the driver to wait
    // for every outstanding result before sending that command
    in_t  pend_q [$];
    bit   drain_q [$];
    // Predicted results, oldest first
    out_t result_q [$];

    int   mismatches  = 0;
    int   results_seen = 0;
    int   cycle_cnt   = 0;
    int   stall_cycles = 0;
    int   tx_gap      = 0;
    int   rx_gap      = 0;
    logic s_fire      = 1'b0;

    // Slot named by a handle, or -1 when the tag, the range or occupancy fails
    function automatic int lookup_slot(logic [HANDLE_W-1:0] h);
        if (h[31:24] != TAG_BYTE) return -1;
        if (h[INDEX_W-1:0] >= SLOT_COUNT) return -1;
        if (!tbl_occ[h[SLOT_AW-1:0]]) return -1;
        return int'(h[INDEX_W-1:0]);
    endfunction

    // Apply one command to the shadow table and return the result it causes
    function automatic out_t apply_command(in_t cmd);
        out_t r;
        int   slot;
        r    = '0;
        slot = -1;
        case (cmd.command)
            CMD_CREATE: begin
                if (tbl_live < SLOT_COUNT) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!tbl_occ[i]) begin
                            slot = i;
                            break;
                        end
                    end
                end
                if (slot >= 0) begin
                    tbl_occ[slot]    = 1'b1;
                    tbl_vis[slot]    = 1'b0;
                    tbl_serial[slot] = next_serial;
                    r.object_serial  = next_serial;
                    next_serial      = next_serial + 1'b1;
                    tbl_live         = tbl_live + 1'b1;
                    r.new_handle     = TAG_VALUE | HANDLE_W'(slot);
                end
            end
            CMD_SET_VISIBLE: begin
                slot = lookup_slot(cmd.handle);
                if (slot >= 0) begin
                    // count damage only when the drawable answer flips
                    if (tbl_vis[slot] != cmd.visible_flag) begin
                        damage_seen = damage_seen + 1'b1;
                    end
                    tbl_vis[slot]   = cmd.visible_flag;
                    r.found         = 1'b1;
                    r.drawable      = cmd.visible_flag;
                    r.object_serial = tbl_serial[slot];
                end
            end
            CMD_QUERY: begin
                slot = lookup_slot(cmd.handle);
                if (slot >= 0) begin
                    r.found         = 1'b1;
                    r.drawable      = tbl_vis[slot];
                    r.object_serial = tbl_serial[slot];
                end
            end
            default: begin
                // free all keeps the serial counter and the damage count
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    tbl_occ[i] = 1'b0;
                    tbl_vis[i] = 1'b0;
                end
                tbl_live = '0;
            end
        endcase
        r.live_objects = tbl_live;
        r.damage_total = damage_seen;
        return r;
    endfunction

    task automatic check_field(string nm, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result %0d: %s expected %h, got %h", results_seen, nm, want, got);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_cmd(cmd_t c, logic [HANDLE_W-1:0] h, logic v, bit drain);
        in_t it;
        it.command      = c;
        it.handle       = h;
        it.visible_flag = v;
        pend_q.push_back(it);
        drain_q.push_back(drain);
    endtask

    // Handle for set visible / query. Occupied slots are always 0..filled-1,
    // since slots are only released all at once; bias toward those and mix in
    // out-of-range indexes, bad tags and fully random words.
    function automatic logic [HANDLE_W-1:0] pick_handle(int filled);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return {TAG_BYTE, INDEX_W'($urandom_range(0, filled))};
        if (r < 78) return {TAG_BYTE, INDEX_W'($urandom)};
        if (r < 86) return {8'($urandom), INDEX_W'($urandom_range(0, SLOT_COUNT - 1))};
        return $urandom;
    endfunction

    // Idling is off near the end of the run and during one stretch in four
    function automatic bit idling_on();
        return (pend_q.size() >= CALM_LEVEL) && ((cycle_cnt % 512) >= 128);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: change inputs on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            // previous transaction done (or none in flight): pick what comes next
            if (tx_gap != 0) begin
                tx_gap  = tx_gap - 1;
                s_valid <= 1'b0;
            end else if (idling_on() && $urandom_range(0, 5) == 0) begin
                tx_gap  = $urandom_range(0, 13);
                s_valid <= 1'b0;
            end else if (pend_q.size() != 0 && (!drain_q[0] || result_q.size() == 0)) begin
                s_payload <= pend_q.pop_front();
                void'(drain_q.pop_front());
                s_valid   <= 1'b1;
            end else begin
                // nothing to send, or hold off until every result has arrived
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: ready comes and goes in bursts, regardless of m_valid
    always @(negedge aclk) begin
        if (rx_gap != 0) begin
            rx_gap  = rx_gap - 1;
            m_ready <= 1'b0;
        end else if (idling_on() && $urandom_range(0, 5) == 0) begin
            rx_gap  = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        out_t want;
        cycle_cnt++;
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            // predict at acceptance so the table follows the block's order
            result_q.push_back(apply_command(s_payload));
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: arrived with no prediction waiting", results_seen);
                end
            end else begin
                want = result_q.pop_front();
                check_field("new_handle", want.new_handle, m_payload.new_handle);
                check_field("found", 32'(want.found), 32'(m_payload.found));
                check_field("drawable", 32'(want.drawable), 32'(m_payload.drawable));
                check_field("object_serial", want.object_serial, m_payload.object_serial);
                check_field("live_objects", 32'(want.live_objects),
                            32'(m_payload.live_objects));
                check_field("damage_total", want.damage_total, m_payload.damage_total);
            end
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles = stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int   phase;
        int   filled;
        int   ncreate;
        int   nmix;
        int   pick;
        cmd_t noise_cmd;

        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_occ[i]    = 1'b0;
            tbl_vis[i]    = 1'b0;
            tbl_serial[i] = '0;
        end
        tbl_live    = '0;
        next_serial = '0;
        damage_seen = '0;

        // Directed: empty table, first object, visibility flips and repeats,
        // every way a handle can fail to resolve, free all and reuse of slots
        queue_cmd(CMD_QUERY,       32'h8000_0000, 1'b0, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0000, 1'b1, 1'b0);
        queue_cmd(CMD_CREATE,      32'h0000_0000, 1'b0, 1'b0);
        queue_cmd(CMD_QUERY,       32'h8000_0000, 1'b1, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0000, 1'b1, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0000, 1'b1, 1'b0);
        queue_cmd(CMD_QUERY,       32'h8000_0000, 1'b0, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0000, 1'b0, 1'b0);
        queue_cmd(CMD_CREATE,      32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_cmd(CMD_QUERY,       32'h8100_0000, 1'b0, 1'b0);
        queue_cmd(CMD_QUERY,       32'h0000_0001, 1'b0, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0200, 1'b1, 1'b0);
        queue_cmd(CMD_QUERY,       32'h80FF_FFFF, 1'b1, 1'b0);
        queue_cmd(CMD_QUERY,       32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0005, 1'b1, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0001, 1'b1, 1'b0);
        queue_cmd(CMD_FREE_ALL,    32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_cmd(CMD_QUERY,       32'h8000_0001, 1'b0, 1'b0);
        queue_cmd(CMD_CREATE,      32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_cmd(CMD_QUERY,       32'h8000_0000, 1'b0, 1'b0);
        queue_cmd(CMD_CREATE,      32'h0000_0000, 1'b0, 1'b0);
        queue_cmd(CMD_SET_VISIBLE, 32'h8000_0001, 1'b0, 1'b0);
        queue_cmd(CMD_FREE_ALL,    32'h0000_0000, 1'b0, 1'b0);

        // Random phases: free all, a run of creates (two phases overfill the
        // table), then a mix of lookups with the odd create and noise
        phase  = 0;
        filled = 0;
        while (pend_q.size() < RANDOM_ITEMS + 23) begin
            queue_cmd(CMD_FREE_ALL, $urandom, 1'($urandom), ($urandom_range(0, 3) == 0));
            filled  = 0;
            ncreate = (phase == 1 || phase == 5) ? SLOT_COUNT + 3 : $urandom_range(1, 40);
            repeat (ncreate) begin
                queue_cmd(CMD_CREATE, $urandom, 1'($urandom), 1'b0);
                if (filled < SLOT_COUNT) filled++;
            end
            nmix = $urandom_range(20, 80);
            repeat (nmix) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    queue_cmd(CMD_CREATE, $urandom, 1'($urandom), 1'b0);
                    if (filled < SLOT_COUNT) filled++;
                end else if (pick <= 4) begin
                    queue_cmd(CMD_SET_VISIBLE, pick_handle(filled), 1'($urandom), 1'b0);
                end else if (pick <= 8) begin
                    queue_cmd(CMD_QUERY, pick_handle(filled), 1'($urandom), 1'b0);
                end else begin
                    noise_cmd = cmd_t'($urandom_range(0, 3));
                    queue_cmd(noise_cmd, $urandom, 1'($urandom), 1'b0);
                    if (noise_cmd == CMD_FREE_ALL) begin
                        filled = 0;
                    end else if (noise_cmd == CMD_CREATE && filled < SLOT_COUNT) begin
                        filled++;
                    end
                end
            end
            phase++;
        end

        // Reset: held low, then released on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wait for every transaction to be taken, then for every result
        while (pend_q.size() != 0 || s_valid) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
